// ===== hdl/grid_local_max_detector_top_assert.svh =====
// assertion macros shared by the peak detector modules
`ifndef GRID_LOCAL_MAX_DETECTOR_TOP_ASSERT_SVH
`define GRID_LOCAL_MAX_DETECTOR_TOP_ASSERT_SVH

// condition must never hold at a clock edge outside reset
`define GLD_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define GLD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/gld_pkg.sv =====
// shared types and constants of the grid peak detector
package gld_pkg;

  localparam int DEF_MAX_COLS    = 1024;
  localparam int DEF_MAX_ROWS    = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int PEAK_W    = 10;

  localparam logic [CFG_W-1:0] GRID_DIM_RESET = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd1;

  // hit bit positions, also the order in which results leave
  localparam int HIT_UP   = 0;
  localparam int HIT_LEFT = 1;
  localparam int HIT_SELF = 2;
  localparam int HIT_W    = 3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // decision record: position of the arriving cell and which cells it decided as peaks
  typedef struct packed {
    logic [PEAK_W-1:0] row;
    logic [PEAK_W-1:0] col;
    logic [HIT_W-1:0]  hits;
  } rec_t;

  typedef struct packed {
    logic full;
    logic almost_full;
  } q_level_t;

endpackage

// ===== hdl/grid_local_max_detector_top.sv =====
// Four-neighbor local maximum detector over a streamed raster. Samples enter
// in row-major order, one per clock when the result side keeps up; a cell is
// reported when it is greater than or equal to each of its existing up, down,
// left and right neighbors (ties are peaks, missing neighbors are ignored).
// The arriving cell (r,c) decides cell (r-1,c); in the last row it also
// decides (r,c-1), and the frame's final cell decides itself, so one sample
// yields zero to three peak requests, in row-major order, the last one marked
// by last_of_run. Throughput is one sample per cycle while full is low, set
// by the two-port line buffer ram read once per sample; the result side gives
// a sample's peak requests out one per pop, and a four-record queue between
// the compare stage and the result side absorbs bursts. A request reaches the
// result ports through the stage b registers and the queue. The line buffer
// holds the two previous rows in one ram of MAX_COLS words and is never
// cleared: words the frame reads before writing them are masked by position
// checks. A config write restarts the frame at cell (0,0); a dimension of
// zero acts as one, and one above the maximum acts as the maximum.
module grid_local_max_detector_top #(
  parameter int MAX_COLS    = gld_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS    = gld_pkg::DEF_MAX_ROWS,
  parameter int SAMPLE_BITS = gld_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  // config write port, register 0 rows, register 1 columns
  input  logic                          cfg_wr_en,
  input  logic [gld_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gld_pkg::CFG_W-1:0]     cfg_data,
  // sample input, taken when push is high and full is low
  input  logic                          push,
  output logic                          full,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  // peak requests, taken when pop is high and empty is low
  output logic                          empty,
  input  logic                          pop,
  output logic [gld_pkg::PEAK_W-1:0]    peak_row,
  output logic [gld_pkg::PEAK_W-1:0]    peak_col,
  output logic                          last_of_run
);
  import gld_pkg::*;

  // front to queue
  logic      rec_push;
  rec_t      rec;
  q_level_t  q_lvl;
  // queue to back
  logic      head_valid;
  rec_t      head_rec;
  logic      rec_pop;

  // position tracking, line buffer, and the three neighbor decisions
  gld_front #(
    .MAX_COLS    (MAX_COLS),
    .MAX_ROWS    (MAX_ROWS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .sample    (sample),
    .full      (full),
    .q_lvl     (q_lvl),
    .rec_push  (rec_push),
    .rec       (rec)
  );

  // only samples that decided at least one peak leave a record here
  gld_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (rec_push),
    .push_rec   (rec),
    .lvl        (q_lvl),
    .pop        (rec_pop),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  // one peak request per cycle while pop is high, from the oldest record
  gld_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_rec    (head_rec),
    .rec_pop     (rec_pop),
    .empty       (empty),
    .pop         (pop),
    .peak_row    (peak_row),
    .peak_col    (peak_col),
    .last_of_run (last_of_run)
  );

endmodule

// ===== hdl/gld_ram.sv =====
// generic ram, one write port and two registered read ports
module gld_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr_a,
  output logic [WIDTH-1:0] rd_data_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ===== hdl/gld_front.sv =====
// front end: config, raster position, line buffer and neighbor compares
module gld_front #(
  parameter int MAX_COLS    = 1024,
  parameter int MAX_ROWS    = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [gld_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gld_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              push,
  input  logic signed [SAMPLE_BITS-1:0]     sample,
  output logic                              full,
  input  gld_pkg::q_level_t                 q_lvl,
  output logic                              rec_push,
  output gld_pkg::rec_t                     rec
);
  import gld_pkg::*;

  `include "grid_local_max_detector_top_assert.svh"

  localparam int CB = $clog2(MAX_COLS);
  localparam int RB = $clog2(MAX_ROWS);
  localparam int CW = (CB + 1 > CFG_W) ? CB + 1 : CFG_W;
  localparam int RW = (RB + 1 > CFG_W) ? RB + 1 : CFG_W;
  localparam int WW = 2 * SAMPLE_BITS;

  typedef struct packed {
    logic r_ge1;
    logic r_ge2;
    logic c_ge1;
    logic c_ge2;
    logic last_row;
    logic last_col;
  } pos_t;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v, input int maxv);
    logic [CFG_W-1:0] res;
    if (v == '0) begin
      res = CFG_W'(1);
    end else if (int'(v) > maxv) begin
      res = CFG_W'(maxv);
    end else begin
      res = v;
    end
    return res;
  endfunction

  logic [CFG_W-1:0] grid_rows;
  logic [CFG_W-1:0] grid_cols;
  logic [RB-1:0]    row_counter;
  logic [CB-1:0]    col_counter;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] left_left_sample;

  logic accept;
  pos_t pos;
  logic [CB-1:0] col_inc;
  logic [CB-1:0] rd_addr_a;
  logic [CB-1:0] rd_addr_b;

  // stage b: item whose line buffer words are being read
  logic                          sb_valid;
  logic signed [SAMPLE_BITS-1:0] sb_s;
  logic [CB-1:0]                 sb_c;
  logic [PEAK_W-1:0]             sb_row;
  logic [PEAK_W-1:0]             sb_col;
  logic signed [SAMPLE_BITS-1:0] sb_left;
  logic signed [SAMPLE_BITS-1:0] sb_left_left;
  pos_t                          sb_pos;
  logic signed [SAMPLE_BITS-1:0] last_ctr;

  logic          wr_en;
  logic [CB-1:0] wr_addr;
  logic [WW-1:0] wr_data;
  logic [WW-1:0] ram_qa;
  logic [WW-1:0] ram_qb;
  logic          fwd_a;
  logic          fwd_b;
  logic [WW-1:0] fwd_word;
  logic [WW-1:0] word_a;
  logic [WW-1:0] word_b;

  logic signed [SAMPLE_BITS-1:0] ctr;
  logic signed [SAMPLE_BITS-1:0] up_val;
  logic signed [SAMPLE_BITS-1:0] right_val;
  logic [HIT_W-1:0] hits;

  assign full   = q_lvl.full || (sb_valid && q_lvl.almost_full);
  assign accept = push && !full;

  always_comb begin
    pos.r_ge1    = (row_counter != '0);
    pos.r_ge2    = (RW'(row_counter) > RW'(1));
    pos.c_ge1    = (col_counter != '0);
    pos.c_ge2    = (CW'(col_counter) > CW'(1));
    pos.last_row = ((RW'(row_counter) + RW'(1)) >= RW'(grid_rows));
    pos.last_col = ((CW'(col_counter) + CW'(1)) >= CW'(grid_cols));
  end

  assign col_inc   = col_counter + CB'(1);
  assign rd_addr_a = col_counter;
  assign rd_addr_b = pos.last_col ? col_counter : col_inc;

  // config and raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows        <= clamp_dim(GRID_DIM_RESET, MAX_ROWS);
      grid_cols        <= clamp_dim(GRID_DIM_RESET, MAX_COLS);
      row_counter      <= '0;
      col_counter      <= '0;
      left_sample      <= '0;
      left_left_sample <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GRID_ROWS: grid_rows <= clamp_dim(cfg_data, MAX_ROWS);
        REG_GRID_COLS: grid_cols <= clamp_dim(cfg_data, MAX_COLS);
      endcase
      row_counter      <= '0;
      col_counter      <= '0;
      left_sample      <= '0;
      left_left_sample <= '0;
    end else if (accept) begin
      left_left_sample <= left_sample;
      left_sample      <= sample;
      if (pos.last_col) begin
        col_counter <= '0;
        row_counter <= pos.last_row ? '0 : row_counter + RB'(1);
      end else begin
        col_counter <= col_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_valid <= 1'b0;
    end else begin
      sb_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sb_s         <= sample;
      sb_c         <= col_counter;
      sb_row       <= PEAK_W'(row_counter);
      sb_col       <= PEAK_W'(col_counter);
      sb_left      <= left_sample;
      sb_left_left <= left_left_sample;
      sb_pos       <= pos;
    end
    if (sb_valid) begin
      last_ctr <= ctr;
    end
    // write of stage b lands after the read issued in the same cycle
    fwd_a    <= wr_en && (wr_addr == rd_addr_a);
    fwd_b    <= wr_en && (wr_addr == rd_addr_b);
    fwd_word <= wr_data;
  end

  // line buffer word: upper half row r-2, lower half row r-1
  gld_ram #(
    .WIDTH (WW),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (ram_qa),
    .rd_addr_b (rd_addr_b),
    .rd_data_b (ram_qb)
  );

  assign word_a    = fwd_a ? fwd_word : ram_qa;
  assign word_b    = fwd_b ? fwd_word : ram_qb;
  assign ctr       = word_a[SAMPLE_BITS-1:0];
  assign up_val    = word_a[WW-1:SAMPLE_BITS];
  assign right_val = word_b[SAMPLE_BITS-1:0];

  assign wr_en   = sb_valid;
  assign wr_addr = sb_c;
  assign wr_data = {word_a[SAMPLE_BITS-1:0], sb_s};

  always_comb begin
    // cell above the arriving one, arriving sample is its lower neighbor
    hits[HIT_UP] = sb_pos.r_ge1 && (ctr >= sb_s)
                   && !(sb_pos.r_ge2 && (ctr < up_val))
                   && !(sb_pos.c_ge1 && (ctr < last_ctr))
                   && !(!sb_pos.last_col && (ctr < right_val));
    // last row: cell to the left, arriving sample is its right neighbor
    hits[HIT_LEFT] = sb_pos.last_row && sb_pos.c_ge1 && (sb_left >= sb_s)
                     && !(sb_pos.r_ge1 && (sb_left < last_ctr))
                     && !(sb_pos.c_ge2 && (sb_left < sb_left_left));
    // final cell of the frame
    hits[HIT_SELF] = sb_pos.last_row && sb_pos.last_col
                     && !(sb_pos.r_ge1 && (sb_s < ctr))
                     && !(sb_pos.c_ge1 && (sb_s < sb_left));
  end

  assign rec_push = sb_valid && (hits != '0);
  assign rec.row  = sb_row;
  assign rec.col  = sb_col;
  assign rec.hits = hits;

  `GLD_ASSERT_NEXT(a_cfg_restart, cfg_wr_en, (row_counter == '0) && (col_counter == '0), "config write did not restart the frame")
  `GLD_ASSERT_NEVER(a_push_overrun, rec_push && q_lvl.full, "decision record pushed into a full queue")

endmodule

// ===== hdl/gld_queue.sv =====
// small fifo of decision records between front and back
module gld_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  gld_pkg::rec_t     push_rec,
  output gld_pkg::q_level_t lvl,
  input  logic              pop,
  output logic              head_valid,
  output gld_pkg::rec_t     head_rec
);
  import gld_pkg::*;

  `include "grid_local_max_detector_top_assert.svh"

  rec_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign do_pop          = pop && head_valid;
  assign head_valid      = (count != '0);
  assign head_rec        = entries[rd_ptr];
  assign lvl.full        = (count == QCNT_W'(QUEUE_DEPTH));
  assign lvl.almost_full = (count >= QCNT_W'(QUEUE_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  `GLD_ASSERT_NEVER(a_count_range, count > QCNT_W'(QUEUE_DEPTH), "queue count beyond depth")

endmodule

// ===== hdl/gld_back.sv =====
// back end: expands each decision record into its peak requests
module gld_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       head_valid,
  input  gld_pkg::rec_t              head_rec,
  output logic                       rec_pop,
  output logic                       empty,
  input  logic                       pop,
  output logic [gld_pkg::PEAK_W-1:0] peak_row,
  output logic [gld_pkg::PEAK_W-1:0] peak_col,
  output logic                       last_of_run
);
  import gld_pkg::*;

  `include "grid_local_max_detector_top_assert.svh"

  logic [HIT_W-1:0] done;
  logic [HIT_W-1:0] remaining;
  logic [HIT_W-1:0] cur;
  logic             take;

  assign remaining   = head_rec.hits & ~done;
  assign empty       = !head_valid;
  assign take        = pop && head_valid;
  assign last_of_run = ((remaining & ~cur) == '0);
  assign rec_pop     = take && last_of_run;

  always_comb begin
    cur = '0;
    priority if (remaining[HIT_UP]) begin
      cur[HIT_UP] = 1'b1;
      peak_row    = head_rec.row - PEAK_W'(1);
      peak_col    = head_rec.col;
    end else if (remaining[HIT_LEFT]) begin
      cur[HIT_LEFT] = 1'b1;
      peak_row      = head_rec.row;
      peak_col      = head_rec.col - PEAK_W'(1);
    end else begin
      cur[HIT_SELF] = 1'b1;
      peak_row      = head_rec.row;
      peak_col      = head_rec.col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= '0;
    end else if (take) begin
      done <= last_of_run ? '0 : (done | cur);
    end
  end

  `GLD_ASSERT_NEXT(a_run_holds, take && !last_of_run, head_valid && (done != '0), "record left before its last peak request")

endmodule
